>>> src/overwrite_ring_buffer_top_assert.svh
// Assertion macros used by the ring buffer RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef OVERWRITE_RING_BUFFER_TOP_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ORB_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ORB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/orb_pkg.sv
// Package for the overwrite ring buffer: item types, command codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package orb_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] latitude_bits;
		logic [63:0] longitude_bits;
		logic [31:0] heading_bits;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] out_latitude;
		logic [63:0] out_longitude;
		logic [31:0] out_heading;
	} rsp_t;

	typedef struct packed {
		logic [63:0] latitude;
		logic [63:0] longitude;
		logic [31:0] heading;
	} rec_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

>>> src/overwrite_ring_buffer_top.sv
// Overwrite ring buffer: a read is staged in the memory, then at the output.
// Throughput is one item per cycle, set by the one read and one write port of
// the record memory; an input stall comes only from a held output.
// Reset zeroes both pointers; the memory is not cleared, since a slot counts
// as valid only between the pointers. An empty buffer reads as zeros.
// Depends on orb_pkg, orb_ptr, orb_mem and overwrite_ring_buffer_top_assert.svh.
`timescale 1ns / 1ps
`include "overwrite_ring_buffer_top_assert.svh"

module overwrite_ring_buffer_top #(
	parameter int DEPTH = orb_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  orb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output orb_pkg::rsp_t rsp
);
	import orb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic          accept;
	mem_ctl_t      ctl;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          nonempty;
	rec_t          wr_data;
	rec_t          rd_data;
	logic          rd_pend_s1;
	logic          found_s1;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = rd_pend_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	assign wr_data.latitude  = req.latitude_bits;
	assign wr_data.longitude = req.longitude_bits;
	assign wr_data.heading   = req.heading_bits;

	orb_ptr #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (req.command),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.nonempty(nonempty)
	);

	orb_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.ctl    (ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else if (ctl.rd_en) begin
			rd_pend_s1 <= 1'b1;
		end else if (out_free) begin
			rd_pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			found_s1 <= nonempty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= rd_pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1 && out_free) begin
			rsp_q.found         <= found_s1;
			rsp_q.out_latitude  <= found_s1 ? rd_data.latitude : '0;
			rsp_q.out_longitude <= found_s1 ? rd_data.longitude : '0;
			rsp_q.out_heading   <= found_s1 ? rd_data.heading : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ORB_ASSERT_NEXT(a_rd_s1, accept && (req.command == CMD_READ), rd_pend_s1, "read not staged")
	`ORB_ASSERT_NEXT(a_s1_held, rd_pend_s1 && rsp_valid && rsp_stall, rd_pend_s1, "held read lost")
	`ORB_ASSERT_NEXT(a_s1_to_out, rd_pend_s1 && out_free, rsp_valid, "read did not reach the output")

endmodule

>>> src/orb_mem.sv
// Record memory of the ring buffer: one write port, one registered read port.
// Depends on orb_pkg.
`timescale 1ns / 1ps

module orb_mem #(
	parameter int DEPTH = orb_pkg::DEPTH_DEFAULT,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  orb_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     wr_addr,
	input  orb_pkg::rec_t     wr_data,
	input  logic [AW-1:0]     rd_addr,
	output orb_pkg::rec_t     rd_data
);
	import orb_pkg::*;

	rec_t mem [DEPTH];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/orb_ptr.sv
// Read and write pointers of the ring buffer and the memory access control.
// Depends on orb_pkg.
`timescale 1ns / 1ps

module orb_ptr #(
	parameter int DEPTH = orb_pkg::DEPTH_DEFAULT,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        command,
	output orb_pkg::mem_ctl_t ctl,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     rd_addr,
	output logic              nonempty
);
	import orb_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] tail_inc;

	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + 1'b1;

	assign nonempty = (head_q != tail_q);
	assign wr_addr  = tail_q;
	assign rd_addr  = head_q;
	assign ctl.wr_en = accept && (command == CMD_WRITE);
	assign ctl.rd_en = accept && (command == CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (accept) begin
			unique case (command)
				CMD_WRITE: begin
					tail_q <= tail_inc;
					if (tail_inc == head_q) begin
						head_q <= head_inc;
					end
				end
				CMD_REMOVE: begin
					if (nonempty) begin
						head_q <= head_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> tb/tb.sv
// Self-checking testbench for overwrite_ring_buffer_top: directed rows, then
// random command sequences checked against an in-bench ring buffer predictor.
// Depends on orb_pkg and the overwrite_ring_buffer_top RTL.
`timescale 1ns / 1ps

module tb;
	import orb_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1290;

	typedef struct {
		req_t req;
		int   reps;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit   cur_typed = 1'b0;
	rsp_t cur_want = '0;
	bit   quiet = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;

	rec_t        slot_rec [DEPTH] = '{default: '0};
	bit          slot_live [DEPTH] = '{default: 1'b0};
	int unsigned oldest = 0;
	int unsigned next_free = 0;

	rsp_t      pending_reads [$];
	plan_row_t plan [$];

	int errors = 0;
	int n_reads = 0, n_writes = 0, n_removes = 0, n_unused = 0;
	int n_overwrites = 0, n_empty_removes = 0, n_checked = 0, n_found = 0;

	overwrite_ring_buffer_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic bit ring_apply(input req_t r, output rsp_t rd);
		rd = '0;
		case (r.command)
			CMD_READ: begin
				n_reads++;
				if (slot_live[oldest]) begin
					rd = {1'b1, slot_rec[oldest]};
				end
				return 1'b1;
			end
			CMD_WRITE: begin
				n_writes++;
				slot_rec[next_free] = {r.latitude_bits, r.longitude_bits, r.heading_bits};
				slot_live[next_free] = 1'b1;
				next_free = (next_free + 1) % DEPTH;
				if (next_free == oldest) begin
					slot_rec[oldest] = '0;
					slot_live[oldest] = 1'b0;
					oldest = (oldest + 1) % DEPTH;
					n_overwrites++;
				end
			end
			CMD_REMOVE: begin
				n_removes++;
				slot_rec[oldest] = '0;
				slot_live[oldest] = 1'b0;
				if (oldest != next_free) begin
					oldest = (oldest + 1) % DEPTH;
				end else begin
					n_empty_removes++;
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t guess;
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				if (ring_apply(req, guess)) begin
					pending_reads.push_back(cur_typed ? cur_want : guess);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_reads.size() == 0) begin
					$error("result with no read waiting: %h", rsp);
					errors++;
				end else begin
					want = pending_reads.pop_front();
					n_checked++;
					if (rsp.found) n_found++;
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errors++;
					end
					if (rsp.out_latitude !== want.out_latitude) begin
						$error("out_latitude: expected %h, got %h",
							want.out_latitude, rsp.out_latitude);
						errors++;
					end
					if (rsp.out_longitude !== want.out_longitude) begin
						$error("out_longitude: expected %h, got %h",
							want.out_longitude, rsp.out_longitude);
						errors++;
					end
					if (rsp.out_heading !== want.out_heading) begin
						$error("out_heading: expected %h, got %h",
							want.out_heading, rsp.out_heading);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 200 == 0) begin
			quiet <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin : stall_gen
		int r;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				rsp_stall <= 1'b0;
			end else if (r < 96) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b1;
				hold_left <= $urandom_range(5, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pick_word64();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic void add_row(input logic [1:0] cmd, input logic [63:0] lat,
			input logic [63:0] lng, input logic [31:0] hdg, input int reps,
			input bit typed, input rsp_t want);
		plan_row_t row;
		row.req = {cmd, lat, lng, hdg};
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	task automatic drive_item(input req_t r, input bit typed, input rsp_t want);
		int gap;
		req <= r;
		cur_typed <= typed;
		cur_want <= want;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		req_t r;
		rsp_t none;
		logic [63:0] word;
		int sent;
		int mode;
		int len;
		int pick;
		none = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(CMD_READ, '0, '0, '0, 1, 1, none);
		add_row(CMD_REMOVE, '0, '0, '0, 1, 0, none);
		add_row(CMD_READ, '1, '1, '1, 1, 1, none);
		add_row(CMD_UNUSED, '1, '1, '1, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, none);
		add_row(CMD_WRITE, '1, '1, '1, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, {1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF});
		add_row(CMD_WRITE, '0, '0, '0, 1, 0, none);
		add_row(CMD_REMOVE, '1, '1, '1, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, {1'b1, 160'h0});
		add_row(CMD_REMOVE, '0, '0, '0, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, none);
		add_row(CMD_REMOVE, '0, '0, '0, 1, 0, none);
		add_row(CMD_WRITE, 64'h4045_0000_0000_1000, 64'hC05E_0000_0000_2000,
			32'h42B4_0000, 20, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 0, none);
		add_row(CMD_REMOVE, '0, '0, '0, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 0, none);
		add_row(CMD_REMOVE, '0, '0, '0, DEPTH, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, none);
		add_row(CMD_WRITE, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			32'h8000_0000, 1, 0, none);
		add_row(CMD_READ, '0, '0, '0, 1, 1, {1'b1, 64'h8000_0000_0000_0000,
			64'h7FF0_0000_0000_0000, 32'h8000_0000});
		add_row(CMD_WRITE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			32'h3F80_0000, 1, 0, none);
		add_row(CMD_READ, '1, '1, '1, 1, 0, none);

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				r = plan[i].req;
				if (r.command == CMD_WRITE) begin
					r.latitude_bits += k;
					r.longitude_bits += k;
					r.heading_bits += k;
				end
				drive_item(r, plan[i].typed, plan[i].want);
			end
		end

		// Episodes lean toward filling, draining, a balanced mix or uniformly random
		// commands so that the buffer reaches both full and empty many times.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 40);
			repeat (len) begin
				pick = $urandom_range(0, 99);
				r.latitude_bits = pick_word64();
				r.longitude_bits = pick_word64();
				word = pick_word64();
				r.heading_bits = word[31:0];
				if (pick < 3) begin
					r.command = CMD_UNUSED;
				end else begin
					case (mode)
						0: r.command = (pick < 60) ? CMD_WRITE :
							(pick < 85) ? CMD_READ : CMD_REMOVE;
						1: r.command = (pick < 20) ? CMD_WRITE :
							(pick < 50) ? CMD_READ : CMD_REMOVE;
						2: r.command = (pick < 40) ? CMD_WRITE :
							(pick < 70) ? CMD_READ : CMD_REMOVE;
						default: r.command = 2'($urandom_range(0, 3));
					endcase
				end
				drive_item(r, 1'b0, none);
				sent++;
			end
		end
		req_valid <= 1'b0;

		while (pending_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d reads, %0d writes, %0d removes and %0d unused commands.",
			n_reads, n_writes, n_removes, n_unused);
		$display("Checked %0d results (%0d found); %0d overwrites when full, %0d %s",
			n_checked, n_found, n_overwrites, n_empty_removes, "removes on empty.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
